// ===== src/dbpu_pkg.sv =====
// Shared types and constants for the debug pause breakpoint unit.
`default_nettype none

package dbpu_pkg;

    localparam int BP_SLOTS_DEF = 16;
    localparam int FUNC_W       = 8;
    localparam int LINE_W       = 16;
    localparam int INSTR_W      = 16;

    typedef enum logic [2:0] {
        OP_INSTR      = 3'd0,
        OP_ADD_BP     = 3'd1,
        OP_REMOVE_BP  = 3'd2,
        OP_CLEAR_BPS  = 3'd3,
        OP_REQ_PAUSE  = 3'd4,
        OP_CONTINUE   = 3'd5,
        OP_STEP       = 3'd6,
        OP_SET_ENABLE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_MANUAL = 2'd1,
        REASON_STEP   = 2'd2,
        REASON_BP     = 2'd3
    } t_reason;

    // Per-word control broadcast to every breakpoint cell.
    typedef struct packed {
        logic              add_we;
        logic              rem_we;
        logic [LINE_W-1:0] key;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== src/dbpu_bp_cell.sv =====
// One breakpoint table slot: holds a line, compares it and shifts on removal.
`default_nettype none

module dbpu_bp_cell
    import dbpu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic              i_occupied,
    input  wire logic              i_tail,
    input  wire logic              i_found,
    input  wire logic [LINE_W-1:0] i_next_line,
    output logic      [LINE_W-1:0] o_line,
    output logic                   o_found
);

    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic              w_hit;

    assign w_hit   = i_occupied && (r_line == i_ctrl.key);
    assign o_found = i_found || w_hit;
    assign o_line  = r_line;

    // A removal pulls the neighbour's line into every slot from the hit onwards.
    always_comb begin
        n_line = r_line;
        if (i_ctrl.add_we && i_tail) begin
            n_line = i_ctrl.key;
        end else if (i_ctrl.rem_we && o_found) begin
            n_line = i_next_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
    end

endmodule

`default_nettype wire

// ===== src/dbpu_bp_table.sv =====
// Row of breakpoint cells with the match chain running along it.
`default_nettype none

module dbpu_bp_table
    import dbpu_pkg::*;
#(
    parameter int BREAKPOINT_SLOTS = BP_SLOTS_DEF,
    localparam int CNT_W = $clog2(BREAKPOINT_SLOTS + 1)
)
(
    input  wire logic             i_clk,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic [CNT_W-1:0] i_count,
    output logic                  o_hit
);

    logic [LINE_W-1:0]       w_line  [BREAKPOINT_SLOTS];
    logic [BREAKPOINT_SLOTS:0] w_found;

    assign w_found[0] = 1'b0;
    assign o_hit      = w_found[BREAKPOINT_SLOTS];

    for (genvar g = 0; g < BREAKPOINT_SLOTS; g++) begin : g_cell
        logic [LINE_W-1:0] w_next;

        if (g == BREAKPOINT_SLOTS - 1) begin : g_last
            assign w_next = w_line[g];
        end else begin : g_mid
            assign w_next = w_line[g+1];
        end

        dbpu_bp_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_occupied  (i_count > CNT_W'(g)),
            .i_tail      (i_count == CNT_W'(g)),
            .i_found     (w_found[g]),
            .i_next_line (w_next),
            .o_line      (w_line[g]),
            .o_found     (w_found[g+1])
        );
    end

endmodule

`default_nettype wire

// ===== src/debug_pause_breakpoint_unit_top.sv =====
// Top level of the debug pause breakpoint unit.
// The result of an accepted word is registered in the output register.
// Throughput: one word per cycle; the breakpoint match ripples along the cell row
// within that cycle, and a new word is taken when the output register is empty or
// its word leaves in the same cycle.
// Reset (synchronous, active low) clears all control flags, locations and the table count;
// the result payload and table slots hold no reset value; slots are never read beyond the count.
`default_nettype none

module debug_pause_breakpoint_unit_top
    import dbpu_pkg::*;
#(
    parameter int BREAKPOINT_SLOTS = BP_SLOTS_DEF
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic [FUNC_W-1:0]  i_function_id,
    input  wire logic [LINE_W-1:0]  i_line,
    input  wire logic [INSTR_W-1:0] i_instr_index,
    input  wire logic               i_enable_flag,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_pause_now,
    output logic [1:0]              o_pause_reason,
    output logic                    o_is_paused,
    output logic                    o_add_dropped
);

    localparam int CNT_W = $clog2(BREAKPOINT_SLOTS + 1);

    logic               r_enabled, n_enabled;
    logic               r_paused, n_paused;
    logic               r_step_mode, n_step_mode;
    logic               r_pending, n_pending;
    t_reason            r_held_reason, n_held_reason;
    logic [FUNC_W-1:0]  r_held_func, n_held_func;
    logic [LINE_W-1:0]  r_held_line, n_held_line;
    logic [INSTR_W-1:0] r_held_instr, n_held_instr;
    logic               r_ss_valid, n_ss_valid;
    logic [FUNC_W-1:0]  r_ss_func, n_ss_func;
    logic [LINE_W-1:0]  r_ss_line, n_ss_line;
    logic               r_skip_valid, n_skip_valid;
    logic               r_skip_whole, n_skip_whole;
    logic [FUNC_W-1:0]  r_skip_func, n_skip_func;
    logic [LINE_W-1:0]  r_skip_line, n_skip_line;
    logic [INSTR_W-1:0] r_skip_instr, n_skip_instr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;

    logic       w_fire;
    logic       w_hit;
    logic       w_skipped;
    t_op        w_op;
    t_reason    w_reason;
    logic       w_dropped;
    t_cell_ctrl w_ctrl;

    assign o_ready = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign w_fire  = i_valid && o_ready;
    assign w_op    = t_op'(i_op);

    dbpu_bp_table #(
        .BREAKPOINT_SLOTS (BREAKPOINT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .o_hit   (w_hit)
    );

    assign w_skipped = r_skip_valid && (r_skip_func == i_function_id) &&
                       (r_skip_line == i_line) &&
                       (r_skip_whole || (r_skip_instr == i_instr_index));

    always_comb begin
        n_enabled     = r_enabled;
        n_paused      = r_paused;
        n_step_mode   = r_step_mode;
        n_pending     = r_pending;
        n_held_reason = r_held_reason;
        n_held_func   = r_held_func;
        n_held_line   = r_held_line;
        n_held_instr  = r_held_instr;
        n_ss_valid    = r_ss_valid;
        n_ss_func     = r_ss_func;
        n_ss_line     = r_ss_line;
        n_skip_valid  = r_skip_valid;
        n_skip_whole  = r_skip_whole;
        n_skip_func   = r_skip_func;
        n_skip_line   = r_skip_line;
        n_skip_instr  = r_skip_instr;
        n_count       = r_count;
        w_reason      = REASON_NONE;
        w_dropped     = 1'b0;
        w_ctrl.add_we = 1'b0;
        w_ctrl.rem_we = 1'b0;
        w_ctrl.key    = i_line;

        if (w_fire) begin
            case (w_op)
                OP_INSTR: begin
                    if (r_enabled && !r_paused && !w_skipped) begin
                        n_skip_valid = 1'b0;
                        n_skip_whole = 1'b0;
                        n_skip_func  = '0;
                        n_skip_line  = '0;
                        n_skip_instr = '0;
                        if (r_pending) begin
                            w_reason  = REASON_MANUAL;
                            n_pending = 1'b0;
                        end else if (r_step_mode) begin
                            // The step completes off the recorded step line and function.
                            if (!(r_ss_valid && (r_ss_line == i_line) &&
                                  (r_ss_func == i_function_id))) begin
                                w_reason    = REASON_STEP;
                                n_step_mode = 1'b0;
                            end
                        end else if ((i_line != '0) && w_hit) begin
                            w_reason = REASON_BP;
                        end
                        if (w_reason != REASON_NONE) begin
                            n_paused      = 1'b1;
                            n_held_reason = w_reason;
                            n_held_func   = i_function_id;
                            n_held_line   = i_line;
                            n_held_instr  = i_instr_index;
                        end
                    end
                end
                OP_ADD_BP: begin
                    if ((i_line != '0) && !w_hit) begin
                        if (r_count < CNT_W'(BREAKPOINT_SLOTS)) begin
                            w_ctrl.add_we = 1'b1;
                            n_count       = r_count + CNT_W'(1);
                        end else begin
                            w_dropped = 1'b1;
                        end
                    end
                end
                OP_REMOVE_BP: begin
                    if (w_hit) begin
                        w_ctrl.rem_we = 1'b1;
                        n_count       = r_count - CNT_W'(1);
                    end
                end
                OP_CLEAR_BPS: begin
                    n_count = '0;
                end
                OP_REQ_PAUSE: begin
                    if (r_enabled) begin
                        n_pending = 1'b1;
                    end
                end
                OP_CONTINUE: begin
                    if (r_paused) begin
                        n_skip_valid  = (r_held_line != '0);
                        n_skip_whole  = (r_held_reason == REASON_BP);
                        n_skip_func   = r_held_func;
                        n_skip_line   = r_held_line;
                        n_skip_instr  = r_held_instr;
                        n_paused      = 1'b0;
                        n_pending     = 1'b0;
                        n_step_mode   = 1'b0;
                        n_held_reason = REASON_NONE;
                        n_held_func   = '0;
                        n_held_line   = '0;
                        n_held_instr  = '0;
                    end
                end
                OP_STEP: begin
                    n_step_mode = 1'b1;
                    n_pending   = 1'b0;
                    if (r_paused) begin
                        n_skip_valid  = (r_held_line != '0);
                        n_skip_whole  = 1'b0;
                        n_skip_func   = r_held_func;
                        n_skip_line   = r_held_line;
                        n_skip_instr  = r_held_instr;
                        n_ss_valid    = 1'b1;
                        n_ss_func     = r_held_func;
                        n_ss_line     = r_held_line;
                        n_paused      = 1'b0;
                        n_held_reason = REASON_NONE;
                        n_held_func   = '0;
                        n_held_line   = '0;
                        n_held_instr  = '0;
                    end
                end
                OP_SET_ENABLE: begin
                    n_enabled     = i_enable_flag;
                    n_paused      = 1'b0;
                    n_step_mode   = 1'b0;
                    n_pending     = 1'b0;
                    n_held_reason = REASON_NONE;
                    n_held_func   = '0;
                    n_held_line   = '0;
                    n_held_instr  = '0;
                    n_ss_valid    = 1'b0;
                    n_ss_func     = '0;
                    n_ss_line     = '0;
                    n_skip_valid  = 1'b0;
                    n_skip_whole  = 1'b0;
                    n_skip_func   = '0;
                    n_skip_line   = '0;
                    n_skip_instr  = '0;
                    if (!i_enable_flag) begin
                        n_count = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_paused      <= 1'b0;
            r_step_mode   <= 1'b0;
            r_pending     <= 1'b0;
            r_held_reason <= REASON_NONE;
            r_held_func   <= '0;
            r_held_line   <= '0;
            r_held_instr  <= '0;
            r_ss_valid    <= 1'b0;
            r_ss_func     <= '0;
            r_ss_line     <= '0;
            r_skip_valid  <= 1'b0;
            r_skip_whole  <= 1'b0;
            r_skip_func   <= '0;
            r_skip_line   <= '0;
            r_skip_instr  <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_enabled     <= n_enabled;
            r_paused      <= n_paused;
            r_step_mode   <= n_step_mode;
            r_pending     <= n_pending;
            r_held_reason <= n_held_reason;
            r_held_func   <= n_held_func;
            r_held_line   <= n_held_line;
            r_held_instr  <= n_held_instr;
            r_ss_valid    <= n_ss_valid;
            r_ss_func     <= n_ss_func;
            r_ss_line     <= n_ss_line;
            r_skip_valid  <= n_skip_valid;
            r_skip_whole  <= n_skip_whole;
            r_skip_func   <= n_skip_func;
            r_skip_line   <= n_skip_line;
            r_skip_instr  <= n_skip_instr;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result word payload; only loaded when a new word is taken in.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_pause_now    <= (w_reason != REASON_NONE);
            o_pause_reason <= w_reason;
            o_is_paused    <= n_paused;
            o_add_dropped  <= w_dropped;
        end
    end

endmodule

`default_nettype wire
